FILE: design/qfs_pkg.sv
// shared constants, request codes and stage control type for the quadgram scorer
package qfs_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int MAX_TEXT_LEN  = 128;
    localparam int SCORE_WIDTH   = 16;

    // port field widths
    localparam int REQ_W    = 2;
    localparam int LETTER_W = 5;
    localparam int INDEX_W  = 19;
    localparam int VALUE_W  = 16;
    localparam int ACC_W    = 24;
    localparam int WIN_W    = 7;

    localparam int PREFIX_LEN  = 3;
    localparam int TABLE_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LET_W       = $clog2(ALPHABET_SIZE);
    localparam int CNT_W       = $clog2(MAX_TEXT_LEN + 1);
    localparam int WC_W        = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int WIN_MAX     = 2 ** WIN_W - 1;

    localparam int SUM_W   = ((SCORE_WIDTH > ACC_W) ? SCORE_WIDTH : ACC_W) + 1;
    localparam int ACC_HI  = 2 ** (ACC_W - 1) - 1;
    localparam int ACC_LO  = -(2 ** (ACC_W - 1));

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_SCORE = 2'd2
    } qfs_req_t;

    localparam logic RES_SCORE = 1'b0;
    localparam logic RES_READ  = 1'b1;

    // control that travels with a word from the table access stage to the sum stage
    typedef struct packed {
        logic             has_result;
        logic             kind;
        logic             add_en;
        logic             use_data;
        logic             last;
        logic [WIN_W-1:0] windows;
    } qfs_ctl_t;

endpackage

FILE: design/qfs_if.sv
// valid/ready channels for request and result words
interface qfs_req_if;
    logic                          valid;
    logic                          ready;
    logic [qfs_pkg::REQ_W-1:0]     req_type;
    logic [qfs_pkg::LETTER_W-1:0]  letter;
    logic                          last;
    logic [qfs_pkg::INDEX_W-1:0]   entry_index;
    logic signed [qfs_pkg::VALUE_W-1:0] entry_value;

    modport source (output valid, req_type, letter, last, entry_index, entry_value,
                    input ready);
    modport sink   (input valid, req_type, letter, last, entry_index, entry_value,
                    output ready);
endinterface

interface qfs_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               result_kind;
    logic signed [qfs_pkg::ACC_W-1:0]   result_value;
    logic [qfs_pkg::WIN_W-1:0]          window_total;

    modport source (output valid, result_kind, result_value, window_total, input ready);
    modport sink   (input valid, result_kind, result_value, window_total, output ready);
endinterface

FILE: design/qfs_table_ram.sv
// quadgram score table: single port synchronous ram with registered read
module qfs_table_ram
(
    input  logic                            clk,
    input  logic                            we,
    input  logic                            re,
    input  logic [qfs_pkg::ADDR_W-1:0]      addr,
    input  logic [qfs_pkg::SCORE_WIDTH-1:0] wdata,
    output logic [qfs_pkg::SCORE_WIDTH-1:0] rdata
);
    import qfs_pkg::*;

    logic [SCORE_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [SCORE_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/qfs_window.sv
// letter window, table address generation and request decode
module qfs_window
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [qfs_pkg::REQ_W-1:0]       req_type,
    input  logic [qfs_pkg::LETTER_W-1:0]    letter,
    input  logic                            last,
    input  logic [qfs_pkg::INDEX_W-1:0]     entry_index,
    input  logic signed [qfs_pkg::VALUE_W-1:0] entry_value,
    output logic                            mem_we,
    output logic                            mem_re,
    output logic [qfs_pkg::ADDR_W-1:0]      mem_addr,
    output logic [qfs_pkg::SCORE_WIDTH-1:0] mem_wdata,
    output logic                            ctl_load,
    output qfs_pkg::qfs_ctl_t               ctl
);
    import qfs_pkg::*;

    localparam logic [INDEX_W:0]    DEPTH_CMP  = (INDEX_W + 1)'(TABLE_DEPTH);
    localparam logic [LETTER_W-1:0] LETTER_TOP = LETTER_W'(ALPHABET_SIZE - 1);
    localparam logic [ADDR_W-1:0]   MUL1       = ADDR_W'(ALPHABET_SIZE);
    localparam logic [ADDR_W-1:0]   MUL2       = ADDR_W'(ALPHABET_SIZE * ALPHABET_SIZE);
    localparam logic [ADDR_W-1:0]   MUL3       =
        ADDR_W'(ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE);
    localparam logic [CNT_W-1:0]    TEXT_MAX   = CNT_W'(MAX_TEXT_LEN);
    localparam logic [CNT_W-1:0]    PREFIX_CNT = CNT_W'(PREFIX_LEN);

    logic [LET_W-1:0]  hist1_reg, hist1_next;
    logic [LET_W-1:0]  hist2_reg, hist2_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;

    logic [LET_W-1:0]  let_sat;
    logic              is_write, is_read, is_score;
    logic              idx_ok, in_len, do_score;
    logic [CNT_W-1:0]  seen_after;
    logic [WC_W-1:0]   win_raw;
    logic [WIN_W-1:0]  win_sat;

    always_comb
    begin
        is_write = (req_type == REQ_WRITE);
        is_read  = (req_type == REQ_READ);
        is_score = (req_type == REQ_SCORE);
        idx_ok   = ({1'b0, entry_index} < DEPTH_CMP);
        let_sat  = (letter > LETTER_TOP) ? LET_W'(LETTER_TOP) : LET_W'(letter);
        in_len   = (seen_reg < TEXT_MAX);
        do_score = in_len && (seen_reg >= PREFIX_CNT);

        seen_after = in_len ? seen_reg + 1'b1 : seen_reg;
        win_raw    = (seen_after > PREFIX_CNT) ? WC_W'(seen_after - PREFIX_CNT) : '0;
        win_sat    = (win_raw > WC_W'(WIN_MAX)) ? WIN_W'(WIN_MAX) : WIN_W'(win_raw);
    end

    // table port: base already holds the three earlier letters
    always_comb
    begin
        mem_we    = accept && is_write && idx_ok;
        mem_re    = accept && ((is_read && idx_ok) || (is_score && do_score));
        mem_addr  = is_score ? base_reg + ADDR_W'(let_sat) : ADDR_W'(entry_index);
        mem_wdata = SCORE_WIDTH'(entry_value);
    end

    always_comb
    begin
        ctl            = '0;
        ctl.kind       = is_read ? RES_READ : RES_SCORE;
        ctl.has_result = is_read || (is_score && last);
        ctl.add_en     = is_score && do_score;
        ctl.use_data   = is_read && idx_ok;
        ctl.last       = is_score && last;
        ctl.windows    = is_score ? win_sat : '0;
        ctl_load       = accept && (ctl.has_result || ctl.add_en);
    end

    always_comb
    begin
        hist1_next = hist1_reg;
        hist2_next = hist2_reg;
        base_next  = base_reg;
        seen_next  = seen_reg;
        if (accept && is_score)
        begin
            if (last)
            begin
                hist1_next = '0;
                hist2_next = '0;
                base_next  = '0;
                seen_next  = '0;
            end
            else if (in_len)
            begin
                hist1_next = hist2_reg;
                hist2_next = let_sat;
                base_next  = ADDR_W'(hist1_reg) * MUL3 + ADDR_W'(hist2_reg) * MUL2
                           + ADDR_W'(let_sat) * MUL1;
                seen_next  = seen_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist1_reg <= '0;
            hist2_reg <= '0;
            base_reg  <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            hist1_reg <= hist1_next;
            hist2_reg <= hist2_next;
            base_reg  <= base_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

FILE: design/qfs_accum.sv
// saturating score accumulator and output word register
module qfs_accum
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ctl_load,
    input  qfs_pkg::qfs_ctl_t               ctl,
    input  logic [qfs_pkg::SCORE_WIDTH-1:0] rdata,
    output logic                            take,
    qfs_rsp_if.source                       rsp
);
    import qfs_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(ACC_HI);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(ACC_LO);

    logic                    s1_valid_reg;
    qfs_ctl_t                s1_ctl_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_kind_reg;
    logic signed [ACC_W-1:0] out_value_reg;
    logic [WIN_W-1:0]        out_win_reg;

    logic                          s1_adv, s1_fire;
    logic signed [SCORE_WIDTH-1:0] addend;
    logic signed [ACC_W-1:0]       base;
    logic signed [SUM_W-1:0]       sum;
    logic signed [ACC_W-1:0]       sat;

    // the sum stage only waits when it holds a result word and the output is full and not taken
    always_comb
    begin
        s1_adv  = !s1_ctl_reg.has_result || !out_valid_reg || rsp.ready;
        s1_fire = s1_valid_reg && s1_adv;
        take    = !s1_valid_reg || s1_adv;
    end

    // one adder serves both the text sum and the clamp of a read back entry
    always_comb
    begin
        addend = (s1_ctl_reg.add_en || s1_ctl_reg.use_data) ? $signed(rdata) : '0;
        base   = (s1_ctl_reg.kind == RES_READ) ? '0 : acc_reg;
        sum    = SUM_W'(base) + SUM_W'(addend);
        if (sum > SAT_HI)
        begin
            sat = ACC_W'(SAT_HI);
        end
        else if (sum < SAT_LO)
        begin
            sat = ACC_W'(SAT_LO);
        end
        else
        begin
            sat = sum[ACC_W-1:0];
        end

        acc_next = acc_reg;
        if (s1_fire && (s1_ctl_reg.kind == RES_SCORE))
        begin
            acc_next = s1_ctl_reg.last ? '0 : (s1_ctl_reg.add_en ? sat : acc_reg);
        end

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_ctl_reg.has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= ctl_load;
            end
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && ctl_load)
        begin
            s1_ctl_reg <= ctl;
        end
        if (s1_fire && s1_ctl_reg.has_result)
        begin
            out_kind_reg  <= s1_ctl_reg.kind;
            out_value_reg <= (s1_ctl_reg.kind == RES_SCORE && !s1_ctl_reg.add_en)
                             ? acc_reg : sat;
            out_win_reg   <= s1_ctl_reg.windows;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_kind  = out_kind_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.window_total = out_win_reg;

endmodule

FILE: design/quadgram_fitness_scorer.sv
// quadgram fitness scorer top level
//
// req carries one word per handshake: a table write, a table read or one
// letter of a text. rsp carries a word for each read and for each letter
// marked last: the saturated Q13.10 text sum and the number of four-letter
// windows scored, or the entry read back.
// The table lives in one single-port ram with a registered read;
// each word uses the port at most once in the cycle it is accepted, so a new
// word is taken every cycle while req.ready stays high. A result word is
// registered in the sum stage and then in the output register.
// The running sum sits one stage behind the table read, so consecutive
// letters add in order without any forwarding.
// When rsp stalls with a word waiting, the next result word waits in the
// sum stage and req.ready drops until rsp takes the waiting word; words
// that give no result keep flowing while the sum stage is free.
// Reset clears the letter window, count, sum and all valid flags; it does
// not clear the table, whose entries must be written before use.
module quadgram_fitness_scorer
(
    input  logic      clk,
    input  logic      rst_n,
    qfs_req_if.sink   req,
    qfs_rsp_if.source rsp
);
    import qfs_pkg::*;

    logic                   accept;
    logic                   take;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_addr;
    logic [SCORE_WIDTH-1:0] mem_wdata;
    logic [SCORE_WIDTH-1:0] mem_rdata;
    logic                   ctl_load;
    qfs_ctl_t               ctl;

    assign req.ready = take;
    assign accept    = req.valid && take;

    qfs_window u_window
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (req.req_type),
        .letter      (req.letter),
        .last        (req.last),
        .entry_index (req.entry_index),
        .entry_value (req.entry_value),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .ctl_load    (ctl_load),
        .ctl         (ctl)
    );

    qfs_table_ram u_table
    (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    qfs_accum u_accum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_load (ctl_load),
        .ctl      (ctl),
        .rdata    (mem_rdata),
        .take     (take),
        .rsp      (rsp)
    );

endmodule

FILE: tb/tb_quadgram_fitness_scorer.sv
// self-checking testbench for the quadgram fitness scorer
module tb_quadgram_fitness_scorer;
    import qfs_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned INDEX_SPAN   = 2 ** INDEX_W;
    localparam int RANDOM_WORDS = 1150;
    localparam int RANDOM_PHASES = 4;
    localparam int MAX_GAP      = 18;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic              kind;
        logic [ACC_W-1:0]  value;
        logic [WIN_W-1:0]  windows;
    } scorer_result_t;

    // tracks table contents and text state, queues the words the block owes
    class fitness_ledger;
        logic [SCORE_WIDTH-1:0] entry_mem[int];
        int unsigned            window_q[PREFIX_LEN];
        int unsigned            letters_in_text;
        logic [ACC_W-1:0]       running_sum;
        scorer_result_t         due_results[$];
        int                     errors;
        int                     texts_scored;
        int                     reads_checked;

        function logic [SCORE_WIDTH-1:0] lookup(int unsigned idx);
            return entry_mem.exists(idx) ? entry_mem[idx] : '0;
        endfunction

        function void clear_text();
            foreach (window_q[k])
                window_q[k] = 0;
            letters_in_text = 0;
            running_sum = '0;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function void take_request(logic [REQ_W-1:0] code, logic [LETTER_W-1:0] letter,
                                   logic last, logic [INDEX_W-1:0] index,
                                   logic [VALUE_W-1:0] value);
            int unsigned            code_l;
            int unsigned            idx;
            int unsigned            windows;
            longint                 acc;
            logic [SCORE_WIDTH-1:0] ent;
            scorer_result_t         res;

            case (code)
                REQ_WRITE:
                begin
                    if (index < TABLE_DEPTH)
                        entry_mem[index] = value[SCORE_WIDTH-1:0];
                end
                REQ_READ:
                begin
                    ent = (index < TABLE_DEPTH) ? lookup(32'(index)) : '0;
                    res.kind = RES_READ;
                    res.value = {{(ACC_W-SCORE_WIDTH){ent[SCORE_WIDTH-1]}}, ent};
                    res.windows = '0;
                    due_results.push_back(res);
                end
                REQ_SCORE:
                begin
                    code_l = (letter > ALPHABET_SIZE - 1) ? ALPHABET_SIZE - 1 : letter;
                    // letters past the length limit only matter for their last mark
                    if (letters_in_text < MAX_TEXT_LEN)
                    begin
                        if (letters_in_text >= PREFIX_LEN)
                        begin
                            idx = ((window_q[0] * ALPHABET_SIZE + window_q[1]) * ALPHABET_SIZE
                                   + window_q[2]) * ALPHABET_SIZE + code_l;
                            ent = lookup(idx);
                            acc = longint'($signed(running_sum)) + longint'($signed(ent));
                            if (acc > ACC_HI)
                                acc = longint'(ACC_HI);
                            if (acc < ACC_LO)
                                acc = longint'(ACC_LO);
                            running_sum = acc[ACC_W-1:0];
                        end
                        window_q[0] = window_q[1];
                        window_q[1] = window_q[2];
                        window_q[2] = code_l;
                        letters_in_text++;
                    end
                    if (last)
                    begin
                        windows = (letters_in_text > PREFIX_LEN) ?
                                  letters_in_text - PREFIX_LEN : 0;
                        if (windows > WIN_MAX)
                            windows = WIN_MAX;
                        res.kind = RES_SCORE;
                        res.value = running_sum;
                        res.windows = windows[WIN_W-1:0];
                        due_results.push_back(res);
                        clear_text();
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void check_result(logic kind, logic [ACC_W-1:0] value,
                                   logic [WIN_W-1:0] windows);
            scorer_result_t want;

            if (due_results.size() == 0)
            begin
                $display("%0t: result word with none expected: kind %0d value %0d windows %0d",
                         $time, kind, $signed(value), windows);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (want.kind !== kind)
            begin
                $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (want.value !== value)
            begin
                $display("%0t: result_value expected %0d actual %0d",
                         $time, $signed(want.value), $signed(value));
                errors++;
            end
            if (want.windows !== windows)
            begin
                $display("%0t: window_total expected %0d actual %0d",
                         $time, want.windows, windows);
                errors++;
            end
            if (want.kind == RES_READ)
                reads_checked++;
            else
                texts_scored++;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    qfs_req_if req_bus();
    qfs_rsp_if rsp_bus();

    quadgram_fitness_scorer i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    fitness_ledger sb;
    bit            entry_known[int];
    int unsigned   known_list[$];
    int            useful_words;
    int            long_texts;
    int            src_gap_max;
    int            sink_gap_max;
    bit            sink_hold_pending;
    int unsigned   cycle_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still due",
                 cycle_count, sb.outstanding());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int draw_gap(int max_gap);
        if (max_gap == 0 || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, max_gap);
    endfunction

    task automatic send_word(input logic [REQ_W-1:0] code, input logic [LETTER_W-1:0] letter,
                             input logic last, input logic [INDEX_W-1:0] index,
                             input logic [VALUE_W-1:0] value);
        int gap;

        gap = draw_gap(src_gap_max);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= code;
        req_bus.letter      <= letter;
        req_bus.last        <= last;
        req_bus.entry_index <= index;
        req_bus.entry_value <= value;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        sb.take_request(code, letter, last, index, value);
        if (code == REQ_WRITE && index < TABLE_DEPTH && !entry_known.exists(index))
        begin
            entry_known[index] = 1'b1;
            known_list.push_back(32'(index));
        end
        if (!(code == REQ_UNUSED || (code == REQ_WRITE && index >= TABLE_DEPTH)))
            useful_words++;
    endtask

    task automatic send_read();
        int unsigned idx;

        // mostly entries already loaded, now and then past the end of the table
        if (known_list.size() == 0 || $urandom_range(0, 4) == 0)
            idx = $urandom_range(TABLE_DEPTH, INDEX_SPAN - 1);
        else
            idx = known_list[$urandom_range(0, known_list.size() - 1)];
        send_word(REQ_READ, LETTER_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                  INDEX_W'(idx), VALUE_W'($urandom));
    endtask

    task automatic send_stray_word();
        int unsigned pick;

        pick = $urandom_range(0, 2);
        if (pick == 0)
            send_read();
        else if (pick == 1)
            send_word(REQ_WRITE, LETTER_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                      INDEX_W'($urandom_range(0, INDEX_SPAN - 1)), VALUE_W'($urandom));
        else
            send_word(REQ_UNUSED, LETTER_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                      INDEX_W'($urandom_range(0, INDEX_SPAN - 1)), VALUE_W'($urandom));
    endtask

    // letters from a small pool so windows repeat; every scored window is loaded first
    task automatic send_text(input int len);
        int unsigned pool[5];
        int unsigned sat_q[$];
        int unsigned raw;
        int unsigned s;
        int unsigned idx;
        int          pool_n;

        pool_n = $urandom_range(2, 5);
        for (int k = 0; k < pool_n; k++)
            pool[k] = $urandom_range(0, ALPHABET_SIZE - 1);
        if (len > MAX_TEXT_LEN)
            long_texts++;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                raw = $urandom_range(ALPHABET_SIZE, 31);
            else
                raw = pool[$urandom_range(0, pool_n - 1)];
            s = (raw > ALPHABET_SIZE - 1) ? ALPHABET_SIZE - 1 : raw;
            sat_q.push_back(s);
            if (i >= PREFIX_LEN && i < MAX_TEXT_LEN)
            begin
                idx = ((sat_q[i-3] * ALPHABET_SIZE + sat_q[i-2]) * ALPHABET_SIZE
                       + sat_q[i-1]) * ALPHABET_SIZE + s;
                if (!entry_known.exists(idx))
                    send_word(REQ_WRITE, LETTER_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)), INDEX_W'(idx), VALUE_W'($urandom));
            end
            if ($urandom_range(0, 11) == 0)
                send_stray_word();
            send_word(REQ_SCORE, LETTER_W'(raw), i == len - 1,
                      INDEX_W'($urandom_range(0, INDEX_SPAN - 1)), VALUE_W'($urandom));
        end
    endtask

    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls per word, one long hold-off on request
    initial
    begin
        int gap;

        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold_pending)
            begin
                sink_hold_pending = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = draw_gap(sink_gap_max);
            if (gap > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_bus.valid !== 1'b1);
            sb.check_result(rsp_bus.result_kind, rsp_bus.result_value, rsp_bus.window_total);
        end
    end

    initial
    begin
        int goal;
        int len;
        int pick;

        sb = new;
        sb.clear_text();
        src_gap_max  = MAX_GAP;
        sink_gap_max = MAX_GAP;
        req_bus.valid       <= 1'b0;
        req_bus.req_type    <= REQ_WRITE;
        req_bus.letter      <= '0;
        req_bus.last        <= 1'b0;
        req_bus.entry_index <= '0;
        req_bus.entry_value <= '0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table extremes, reads in and out of range, unused code
        send_word(REQ_WRITE, 5'd0, 1'b1, 19'd0, 16'h8000);
        send_word(REQ_WRITE, 5'd31, 1'b0, INDEX_W'(TABLE_DEPTH - 1), 16'h7fff);
        send_word(REQ_WRITE, 5'd0, 1'b0, INDEX_W'(TABLE_DEPTH), 16'h1234);
        send_word(REQ_READ, 5'd0, 1'b0, 19'd0, '0);
        send_word(REQ_READ, 5'd0, 1'b1, INDEX_W'(TABLE_DEPTH - 1), '1);
        send_word(REQ_READ, 5'd31, 1'b0, INDEX_W'(INDEX_SPAN - 1), '0);
        send_word(REQ_UNUSED, 5'd31, 1'b1, INDEX_W'(INDEX_SPAN - 1), '1);
        // one window at the most negative entry
        for (int i = 0; i < 4; i++)
            send_word(REQ_SCORE, 5'd0, i == 3, '0, '0);
        // single letter, out of range code
        send_word(REQ_SCORE, 5'd31, 1'b1, '1, '1);
        // saturated codes all map to the top letter
        send_word(REQ_SCORE, 5'd31, 1'b0, '0, '0);
        send_word(REQ_SCORE, 5'd26, 1'b0, '0, '0);
        send_word(REQ_SCORE, 5'd25, 1'b0, '0, '0);
        send_word(REQ_SCORE, 5'd30, 1'b1, '0, '0);
        // three letters give no window
        for (int i = 0; i < 3; i++)
            send_word(REQ_SCORE, 5'd0, i == 2, '0, '0);
        for (int i = 0; i < 5; i++)
            send_word(REQ_SCORE, 5'd0, i == 4, '0, '0);
        drain_results();

        // back-to-back reads against a long result stall fill the pipe
        src_gap_max  = 0;
        sink_gap_max = 0;
        sink_hold_pending = 1'b1;
        repeat (40) send_read();
        drain_results();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            src_gap_max  = (phase == 1 || phase == 3) ? 0 : MAX_GAP;
            sink_gap_max = (phase == 1 || phase == 2) ? 0 : MAX_GAP;
            goal = useful_words + RANDOM_WORDS / RANDOM_PHASES;
            // the first text of the run runs past the length limit
            if (phase == 0)
                send_text($urandom_range(MAX_TEXT_LEN + 1, MAX_TEXT_LEN + 12));
            while (useful_words < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        len = $urandom_range(1, PREFIX_LEN);
                    else if (pick < 11)
                        len = $urandom_range(MAX_TEXT_LEN + 1, MAX_TEXT_LEN + 12);
                    else
                        len = $urandom_range(PREFIX_LEN + 1, 40);
                    send_text(len);
                end
                else if (pick < 75)
                    send_word(REQ_WRITE, LETTER_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)),
                              INDEX_W'($urandom_range(0, INDEX_SPAN - 1)), VALUE_W'($urandom));
                else if (pick < 90)
                    send_read();
                else
                    send_word(REQ_UNUSED, LETTER_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)),
                              INDEX_W'($urandom_range(0, INDEX_SPAN - 1)), VALUE_W'($urandom));
            end
            drain_results();
        end

        $display("sent %0d request words with %0d over-length texts in %0d cycles",
                 useful_words, long_texts, cycle_count);
        $display("checked %0d text scores and %0d table read-backs, %0d entries loaded",
                 sb.texts_scored, sb.reads_checked, known_list.size());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: quadgram_fitness_scorer.f
design/qfs_pkg.sv
design/qfs_if.sv
design/qfs_table_ram.sv
design/qfs_window.sv
design/qfs_accum.sv
design/quadgram_fitness_scorer.sv
tb/tb_quadgram_fitness_scorer.sv
